/* rtl/core/nfps_pkg.sv */
// ----------------------------------------------------------------------------
// nfps_pkg
// Shared codes, field widths and types for the NAND flash page store.
// ----------------------------------------------------------------------------
package nfps_pkg;

  localparam int REQ_W    = 2;
  localparam int BLOCK_W  = 8;
  localparam int PAGE_W   = 6;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int PTR_W    = 7;
  localparam int NBLK_W   = 9;
  localparam int NPG_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // block, page, data, spare: 78 bits, padded to 80
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 2 * WORD_W;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam req_t REQ_READ  = 2'd0;
  localparam req_t REQ_WRITE = 2'd1;
  localparam req_t REQ_ERASE = 2'd2;
  localparam req_t REQ_NOP   = 2'd3;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_BAD_BLOCK  = 3'd1;
  localparam status_t ST_BAD_PAGE   = 3'd2;
  localparam status_t ST_WRITTEN    = 3'd3;
  localparam status_t ST_NOT_SEQ    = 3'd4;
  localparam status_t ST_EMPTY      = 3'd5;
  localparam status_t ST_ERASE_FREE = 3'd6;

  localparam cfg_idx_t CFG_NUM_BLOCKS = 2'd0;
  localparam cfg_idx_t CFG_PAGES      = 2'd1;

  localparam logic [NBLK_W-1:0] NBLK_RST = 9'd256;
  localparam logic [NPG_W-1:0]  NPG_RST  = 7'd64;

endpackage

/* rtl/core/nfps_ram.sv */
// ----------------------------------------------------------------------------
// nfps_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nfps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/nand_flash_page_store_unit.sv */
// ----------------------------------------------------------------------------
// nand_flash_page_store_unit
// NAND flash model: page store with per-block sequential write pointers.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream (read, program, erase of a block/page) and
// each yields one item on the out_ stream: a status code in out_tuser and the
// read data and spare words in out_tdata (zero unless a read succeeded).
// The cfg_ port sets the active block count and pages per block; it is
// always ready and is to be written only while the unit is idle, which the
// block itself does not enforce. For each item the accept cycle reads the
// block pointer RAM and the page RAM; in S_EXEC the unit checks the request,
// writes back the pointer and page, and loads the output register, waiting
// while that register is full. A new request is accepted only in S_IDLE.
// After reset a clearing pass zeroes all MAX_BLOCKS pointer RAM entries,
// one block per cycle, with in_tready low. Page contents are undefined until
// programmed. If out_tready is low the result waits in the output register;
// one more item may be accepted and then holds until the register frees.
// ----------------------------------------------------------------------------
module nand_flash_page_store_unit #(
  parameter int MAX_BLOCKS = 256,
  parameter int MAX_PAGES  = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // block[7:0], page[13:8], data_word[45:14], spare_word[77:46], zero pad
  input  logic [nfps_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type[1:0]
  input  logic [nfps_pkg::REQ_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_data[31:0], read_spare[63:32]
  output logic [nfps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status[2:0]
  output logic [nfps_pkg::STATUS_W-1:0]     out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nfps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfps_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import nfps_pkg::*;

  localparam int BLK_AW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int PG_AW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PS_DEPTH = MAX_BLOCKS * MAX_PAGES;
  localparam int PS_AW    = (PS_DEPTH > 1) ? $clog2(PS_DEPTH) : 1;
  localparam logic [BLK_AW-1:0] CLR_LAST = BLK_AW'(MAX_BLOCKS - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  logic                 clr_active_r, clr_active_nxt;
  logic [BLK_AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [NBLK_W-1:0]    num_blocks_r, num_blocks_nxt;
  logic [NPG_W-1:0]     pages_r, pages_nxt;

  req_t                 req_r;
  logic [BLOCK_W-1:0]   blk_r;
  logic [PAGE_W-1:0]    pg_r;
  logic [WORD_W-1:0]    data_r, spare_r;
  logic [BLK_AW-1:0]    bidx_r;
  logic [PS_AW-1:0]     paddr_r;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [BLOCK_W-1:0]   in_blk;
  logic [PAGE_W-1:0]    in_pg;
  logic [BLK_AW+BLOCK_W-1:0] in_blk_w;
  logic [PG_AW+PAGE_W-1:0]   in_pg_w;
  logic [BLK_AW-1:0]    in_bidx;
  logic [PS_AW-1:0]     in_paddr;
  logic                 in_fire, exec_fire;

  ptr_t                 ptr_rdata;
  logic [2*WORD_W-1:0]  ps_rdata;
  logic                 ptr_we, ps_we;
  logic [BLK_AW-1:0]    ptr_waddr;
  ptr_t                 ptr_wdata;

  status_t              st;
  logic                 bad_block, bad_page, rd_ok;
  ptr_t                 pg7;

  assign in_blk   = in_tdata[BLOCK_W-1:0];
  assign in_pg    = in_tdata[BLOCK_W +: PAGE_W];
  assign in_blk_w = (BLK_AW+BLOCK_W)'(in_blk);
  assign in_pg_w  = (PG_AW+PAGE_W)'(in_pg);
  assign in_bidx  = in_blk_w[BLK_AW-1:0];
  assign in_paddr = PS_AW'(PS_AW'(in_bidx) * PS_AW'(MAX_PAGES))
                  + PS_AW'(in_pg_w[PG_AW-1:0]);

  assign in_tready = (state_r == S_IDLE) && !clr_active_r;
  assign in_fire   = in_tvalid && in_tready;
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  // request checks
  assign pg7       = PTR_W'(pg_r);
  assign bad_block = (32'(blk_r) >= 32'(num_blocks_r)) || (32'(blk_r) >= 32'(MAX_BLOCKS));
  assign bad_page  = (32'(pg_r) >= 32'(pages_r)) || (32'(pg_r) >= 32'(MAX_PAGES));

  always_comb begin
    st        = ST_OK;
    rd_ok     = 1'b0;
    ps_we     = 1'b0;
    ptr_we    = 1'b0;
    ptr_waddr = bidx_r;
    ptr_wdata = '0;
    if (req_r == REQ_NOP) begin
      st = ST_OK;
    end else if (bad_block) begin
      st = ST_BAD_BLOCK;
    end else if (req_r == REQ_ERASE) begin
      if (ptr_rdata == '0) begin
        st = ST_ERASE_FREE;
      end else begin
        ptr_we = exec_fire;
      end
    end else if (bad_page) begin
      st = ST_BAD_PAGE;
    end else if (req_r == REQ_WRITE) begin
      if (pg7 < ptr_rdata) begin
        st = ST_WRITTEN;
      end else if (pg7 != ptr_rdata) begin
        st = ST_NOT_SEQ;
      end else begin
        ps_we     = exec_fire;
        ptr_we    = exec_fire;
        ptr_wdata = ptr_rdata + PTR_W'(1);
      end
    end else begin
      if (pg7 >= ptr_rdata) begin
        st = ST_EMPTY;
      end else begin
        rd_ok = 1'b1;
      end
    end
    if (clr_active_r) begin
      ptr_we    = 1'b1;
      ptr_waddr = clr_cnt_r;
      ptr_wdata = '0;
    end
  end

  nfps_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (in_fire),
    .raddr (in_bidx),
    .rdata (ptr_rdata)
  );

  nfps_ram #(
    .WIDTH (2*WORD_W),
    .DEPTH (PS_DEPTH)
  ) u_page_ram (
    .clk   (clk),
    .we    (ps_we),
    .waddr (paddr_r),
    .wdata ({spare_r, data_r}),
    .re    (in_fire),
    .raddr (in_paddr),
    .rdata (ps_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    num_blocks_nxt = num_blocks_r;
    pages_nxt      = pages_r;
    out_valid_nxt  = out_valid_r;
    if (clr_active_r) begin
      clr_cnt_nxt = clr_cnt_r + BLK_AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_BLOCKS: num_blocks_nxt = cfg_data;
        CFG_PAGES:      pages_nxt      = cfg_data[NPG_W-1:0];
        default: ;
      endcase
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      num_blocks_r <= NBLK_RST;
      pages_r      <= NPG_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      num_blocks_r <= num_blocks_nxt;
      pages_r      <= pages_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r   <= in_tuser;
      blk_r   <= in_blk;
      pg_r    <= in_pg;
      data_r  <= in_tdata[BLOCK_W+PAGE_W +: WORD_W];
      spare_r <= in_tdata[BLOCK_W+PAGE_W+WORD_W +: WORD_W];
      bidx_r  <= in_bidx;
      paddr_r <= in_paddr;
    end
    if (exec_fire) begin
      out_status_r <= st;
      out_data_r   <= rd_ok ? ps_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_data_r;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the NAND flash page store unit.
// ----------------------------------------------------------------------------
// Requests are queued by phase, each phase under its own block/page count
// setting, and pushed through a stream driver with random gaps. Every accepted
// request runs through a local flash model (write pointers plus page memory)
// that queues the expected status and read words. The result monitor stalls at
// random, holds off for long stretches twice, and checks each result field by
// field against the oldest queued expectation.
// ----------------------------------------------------------------------------
module tb;
  import nfps_pkg::*;

  typedef struct {
    req_t        op;
    logic [7:0]  blk;
    logic [5:0]  pg;
    logic [31:0] data;
    logic [31:0] spare;
  } flash_req_t;

  typedef struct {
    status_t     status;
    logic [31:0] rdata;
    logic [31:0] rspare;
  } flash_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  req_t                   in_tuser = REQ_READ;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  status_t                out_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index = CFG_NUM_BLOCKS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // flash model state
  ptr_t        wr_ptr [256];
  logic [63:0] page_mem [16384];
  int          eff_blocks = 256;
  int          eff_pages = 64;

  // write pointers as the stimulus will leave them
  int plan_ptr [256];

  flash_req_t    req_q [$];
  flash_result_t due_results [$];
  flash_req_t    cur_req;
  flash_req_t    tx_next;
  flash_result_t want;
  int            tx_gap = 0;
  int            rx_wait = 0;
  int            rx_wait_n;
  int            rx_count = 0;
  int            err_cnt = 0;
  bit            idle_on = 1'b1;

  nand_flash_page_store_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void flash_apply(flash_req_t r);
    flash_result_t res;
    res.status = ST_OK;
    res.rdata  = '0;
    res.rspare = '0;
    if (r.op == REQ_NOP) begin
      res.status = ST_OK;
    end else if (r.blk >= eff_blocks) begin
      res.status = ST_BAD_BLOCK;
    end else if (r.op == REQ_ERASE) begin
      if (wr_ptr[r.blk] == 0) res.status = ST_ERASE_FREE;
      else wr_ptr[r.blk] = '0;
    end else if (r.pg >= eff_pages) begin
      res.status = ST_BAD_PAGE;
    end else if (r.op == REQ_WRITE) begin
      if (r.pg < wr_ptr[r.blk]) begin
        res.status = ST_WRITTEN;
      end else if (r.pg != wr_ptr[r.blk]) begin
        res.status = ST_NOT_SEQ;
      end else begin
        page_mem[{r.blk, r.pg}] = {r.spare, r.data};
        wr_ptr[r.blk] = wr_ptr[r.blk] + 1'b1;
      end
    end else if (r.pg >= wr_ptr[r.blk]) begin
      res.status = ST_EMPTY;
    end else begin
      res.rdata  = page_mem[{r.blk, r.pg}][31:0];
      res.rspare = page_mem[{r.blk, r.pg}][63:32];
    end
    due_results.push_back(res);
  endfunction

  function automatic void push_req(req_t op, int blk, int pg, logic [31:0] d, logic [31:0] s);
    flash_req_t r;
    r.op    = op;
    r.blk   = blk[7:0];
    r.pg    = pg[5:0];
    r.data  = d;
    r.spare = s;
    if (blk < eff_blocks && op == REQ_ERASE)
      plan_ptr[blk] = 0;
    else if (blk < eff_blocks && op == REQ_WRITE && pg < eff_pages && pg == plan_ptr[blk])
      plan_ptr[blk]++;
    req_q.push_back(r);
  endfunction

  // mostly legal sequences on a few busy blocks, with some noise
  function automatic void random_reqs(int n);
    int b, pg, sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) b = $urandom_range(0, (eff_blocks > 4) ? 3 : eff_blocks);
      else if (sel < 80) b = (eff_blocks == 0) ? 0 : eff_blocks - 1;
      else b = $urandom_range(0, 255);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        pg = ($urandom_range(0, 9) < 8) ? plan_ptr[b] : $urandom_range(0, 63);
        if (pg > 63) pg = 63;
        push_req(REQ_WRITE, b, pg, $urandom, $urandom);
      end else if (sel < 80) begin
        if (plan_ptr[b] != 0 && $urandom_range(0, 9) < 8) pg = $urandom_range(0, plan_ptr[b] - 1);
        else pg = $urandom_range(0, 63);
        push_req(REQ_READ, b, pg, $urandom, $urandom);
      end else if (sel < 93) begin
        push_req(REQ_ERASE, b, $urandom_range(0, 63), $urandom, $urandom);
      end else begin
        push_req(REQ_NOP, b, $urandom_range(0, 63), $urandom, $urandom);
      end
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_NUM_BLOCKS: eff_blocks = (val > 256) ? 256 : int'(val);
      CFG_PAGES:      eff_pages = (val[6:0] > 64) ? 64 : int'(val[6:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (req_q.size() != 0 || in_tvalid || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) flash_apply(cur_req);
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          tx_next = req_q.pop_front();
          cur_req <= tx_next;
          in_tvalid <= 1'b1;
          in_tuser <= tx_next.op;
          in_tdata <= {2'b00, tx_next.spare, tx_next.data, tx_next.pg, tx_next.blk};
          tx_gap <= idle_on ? $urandom_range(0, 7) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
      rx_count <= 0;
    end else if (out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d", out_tuser);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          err_cnt++;
        end
        if (out_tdata[31:0] !== want.rdata) begin
          $error("read_data: expected %h, got %h", want.rdata, out_tdata[31:0]);
          err_cnt++;
        end
        if (out_tdata[63:32] !== want.rspare) begin
          $error("read_spare: expected %h, got %h", want.rspare, out_tdata[63:32]);
          err_cnt++;
        end
      end
      rx_count <= rx_count + 1;
      // long hold-offs let the unit fill up and back-pressure its input
      if (rx_count == 120 || rx_count == 450) rx_wait_n = 100;
      else rx_wait_n = idle_on ? $urandom_range(0, 7) : 0;
      rx_wait <= rx_wait_n;
      out_tready <= (rx_wait_n == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < 256; i++) wr_ptr[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: pointer rules and word extremes
    push_req(REQ_READ,  0, 0, '0, '0);
    push_req(REQ_ERASE, 0, 0, '0, '0);
    push_req(REQ_WRITE, 0, 1, 32'h1234_5678, 32'h9abc_def0);
    push_req(REQ_WRITE, 0, 0, 32'hffff_ffff, 32'h0000_0000);
    push_req(REQ_WRITE, 0, 0, 32'h0, 32'h0);
    push_req(REQ_READ,  0, 0, '0, '0);
    push_req(REQ_WRITE, 0, 1, 32'h0000_0000, 32'hffff_ffff);
    push_req(REQ_READ,  0, 1, '0, '0);
    push_req(REQ_READ,  0, 2, '0, '0);
    push_req(REQ_WRITE, 255, 0, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    push_req(REQ_READ,  255, 0, '0, '0);
    push_req(REQ_READ,  255, 63, '0, '0);
    push_req(REQ_NOP,   255, 63, 32'hffff_ffff, 32'hffff_ffff);
    push_req(REQ_ERASE, 0, 63, '0, '0);
    push_req(REQ_READ,  0, 0, '0, '0);
    push_req(REQ_ERASE, 0, 0, '0, '0);
    wait_idle();

    // counts above the limits saturate; fill one block to the last page
    write_reg(CFG_NUM_BLOCKS, 9'h1ff);
    write_reg(CFG_PAGES, 9'h07f);
    for (int p = 0; p < 64; p++) push_req(REQ_WRITE, 9, p, $urandom, $urandom);
    push_req(REQ_WRITE, 9, 63, $urandom, $urandom);
    push_req(REQ_READ,  9, 63, '0, '0);
    push_req(REQ_READ,  9, 0, '0, '0);
    wait_idle();

    write_reg(CFG_NUM_BLOCKS, 9'd8);
    write_reg(CFG_PAGES, 9'd16);
    random_reqs(150);
    wait_idle();

    // zero counts, unused register indexes
    write_reg(CFG_NUM_BLOCKS, 9'd0);
    write_reg(cfg_idx_t'(2), 9'h1ff);
    write_reg(cfg_idx_t'(3), 9'h1ff);
    push_req(REQ_READ,  0, 0, '0, '0);
    push_req(REQ_WRITE, 0, 0, $urandom, $urandom);
    push_req(REQ_ERASE, 0, 0, '0, '0);
    push_req(REQ_NOP,   0, 0, $urandom, $urandom);
    wait_idle();
    write_reg(CFG_NUM_BLOCKS, 9'd256);
    write_reg(CFG_PAGES, 9'd0);
    push_req(REQ_WRITE, 2, 0, $urandom, $urandom);
    push_req(REQ_READ,  9, 0, '0, '0);
    push_req(REQ_ERASE, 200, 0, '0, '0);
    wait_idle();
    write_reg(CFG_NUM_BLOCKS, 9'd5);
    write_reg(CFG_PAGES, 9'h1c3);
    push_req(REQ_WRITE, 5, 0, $urandom, $urandom);
    push_req(REQ_WRITE, 4, 3, $urandom, $urandom);
    push_req(REQ_WRITE, 4, 0, $urandom, $urandom);
    wait_idle();

    // page count lowered below a full block's pointer; no idling
    write_reg(CFG_NUM_BLOCKS, 9'd256);
    write_reg(CFG_PAGES, 9'd4);
    idle_on = 1'b0;
    push_req(REQ_WRITE, 9, 2, $urandom, $urandom);
    push_req(REQ_READ,  9, 3, '0, '0);
    push_req(REQ_WRITE, 9, 5, $urandom, $urandom);
    random_reqs(200);
    wait_idle();

    idle_on = 1'b1;
    write_reg(CFG_NUM_BLOCKS, 9'd1);
    write_reg(CFG_PAGES, 9'd64);
    random_reqs(150);
    wait_idle();

    write_reg(CFG_NUM_BLOCKS, 9'd256);
    write_reg(CFG_PAGES, 9'd1);
    random_reqs(60);
    wait_idle();

    repeat (8) @(posedge clk);
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
